FILE: hw/rtl/pup_pkg.sv
// ----------------------------------------------------------------------------
// Picture-unit register port package
// Shared beat types, access and register codes, and memory geometry for the
// picture-unit register port.
// ----------------------------------------------------------------------------
package pup_pkg;

  // Memory geometry. The nametable depth is a power of two.
  localparam int NAMETABLE_DEPTH = 2048;
  localparam int PALETTE_DEPTH   = 32;
  localparam int NT_AW           = $clog2(NAMETABLE_DEPTH);
  localparam int PAL_AW          = $clog2(PALETTE_DEPTH);

  // Video address map.
  localparam logic [13:0] PALETTE_BASE   = 14'h3F00;
  localparam logic [13:0] NAMETABLE_BASE = 14'h2000;

  // Access kinds carried in the action field.
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Register indexes.
  localparam logic [2:0] REG_CONTROL     = 3'd0;
  localparam logic [2:0] REG_MASK        = 3'd1;
  localparam logic [2:0] REG_STATUS      = 3'd2;
  localparam logic [2:0] REG_SPRITE_ADDR = 3'd3;
  localparam logic [2:0] REG_SPRITE_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL      = 3'd5;
  localparam logic [2:0] REG_ADDRESS     = 3'd6;
  localparam logic [2:0] REG_DATA        = 3'd7;

  // Reset value of the mask register: both clip bits set.
  localparam logic [7:0] MASK_RESET = 8'h06;

  // Where the read data of a result comes from.
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_STATUS,
    SRC_PALETTE,
    SRC_NAMETABLE
  } read_src_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  reg_select;
    logic [7:0]  write_data;
    logic [13:0] peek_address;
    logic        vblank_set;
    logic        sprite_zero_hit;
    logic        sprite_overflow;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_enable;
    logic [5:0]  control_flags;
    logic [7:0]  mask_flags;
    logic [7:0]  horizontal_scroll;
    logic [7:0]  vertical_scroll;
    logic [13:0] video_address;
    logic        latch_phase;
    logic        half_address_write;
  } out_beat_t;

  // Palette entry for a video address; sprite entry 0 of each group of four
  // mirrors the matching background entry.
  function automatic logic [PAL_AW-1:0] palette_slot(input logic [13:0] addr);
    logic [PAL_AW-1:0] s;
    s = addr[PAL_AW-1:0];
    if (s[4] && (s[1:0] == 2'b00)) begin
      s[4] = 1'b0;
    end
    return s;
  endfunction

endpackage

FILE: hw/rtl/pup_if.sv
// ----------------------------------------------------------------------------
// Picture-unit register port channels
// Valid/ready channels for access beats and result beats.
// ----------------------------------------------------------------------------
interface pup_in_if;
  logic              valid;
  logic              ready;
  pup_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pup_out_if;
  logic               valid;
  logic               ready;
  pup_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/picture_unit_register_port.sv
// A result beat appears in the cycle after its access beat is taken.
// Throughput: one access per cycle while the result sink is ready; each access makes
// at most one palette or nametable access, and both memories have a registered read port.
// A waiting result does not block the next access if the sink takes it that cycle.
// Reset clears the control, scroll, address, phase and vblank registers and sets
// the mask clip bits; the palette and nametable memories hold nothing until written.
// ----------------------------------------------------------------------------
// Picture-unit register port
// CPU register accesses and renderer peeks over a palette and a nametable.
// ----------------------------------------------------------------------------
module picture_unit_register_port (
  input  logic           clk,
  input  logic           rst,
  pup_in_if.sink         access,
  pup_out_if.source      result
);
  import pup_pkg::*;

  // Register state.
  logic              phase_flag, phase_flag_next;
  logic              nmi_enable, nmi_enable_next;
  logic [5:0]        control_flags, control_flags_next;
  logic [7:0]        mask_reg, mask_reg_next;
  logic [7:0]        scroll_h, scroll_h_next;
  logic [7:0]        scroll_v, scroll_v_next;
  logic [13:0]       address_reg, address_reg_next;
  logic              vblank_pending, vblank_pending_next;

  // Result stage.
  logic              out_valid;
  logic              half_write, half_write_next;
  read_src_t         read_src, read_src_next;
  logic [7:0]        status_byte, status_byte_next;

  // Memories and their read registers.
  logic [5:0]        palette_mem [PALETTE_DEPTH];
  logic [7:0]        nametable_mem [NAMETABLE_DEPTH];
  logic [5:0]        pal_rdata;
  logic [7:0]        nt_rdata;

  logic              in_accept;
  logic              vblank_now;
  logic              pal_we, nt_we;
  logic [PAL_AW-1:0] pal_waddr, pal_raddr;
  logic [NT_AW-1:0]  nt_waddr, nt_raddr;
  logic [7:0]        mem_wdata;
  logic              pal_re, nt_re;
  logic [13:0]       addr_step;
  action_t           act;

  // Handshake: a new beat is taken when the result slot is free or being drained.
  assign access.ready = !out_valid || result.ready;
  assign in_accept    = access.valid && access.ready;
  assign act          = action_t'(access.data.action);

  // Decode the access and form the next register values.
  always_comb begin
    phase_flag_next     = phase_flag;
    nmi_enable_next     = nmi_enable;
    control_flags_next  = control_flags;
    mask_reg_next       = mask_reg;
    scroll_h_next       = scroll_h;
    scroll_v_next       = scroll_v;
    address_reg_next    = address_reg;
    half_write_next     = 1'b0;
    read_src_next       = SRC_ZERO;
    status_byte_next    = 8'h00;
    pal_we              = 1'b0;
    nt_we               = 1'b0;
    pal_re              = 1'b0;
    nt_re               = 1'b0;
    mem_wdata           = access.data.write_data;
    pal_waddr           = palette_slot(address_reg);
    nt_waddr            = address_reg[NT_AW-1:0];
    pal_raddr           = palette_slot(access.data.peek_address);
    nt_raddr            = access.data.peek_address[NT_AW-1:0];
    addr_step           = control_flags[2] ? 14'd32 : 14'd1;
    vblank_now          = vblank_pending || access.data.vblank_set;
    vblank_pending_next = vblank_now;

    case (act)
      ACT_READ: begin
        if (access.data.reg_select == REG_STATUS) begin
          read_src_next       = SRC_STATUS;
          status_byte_next    = {vblank_now, access.data.sprite_zero_hit,
                                 access.data.sprite_overflow, 5'b00000};
          vblank_pending_next = 1'b0;
          phase_flag_next     = 1'b0;
        end
      end
      ACT_WRITE: begin
        unique case (access.data.reg_select)
          REG_CONTROL: begin
            nmi_enable_next    = access.data.write_data[7];
            control_flags_next = access.data.write_data[5:0];
          end
          REG_MASK: begin
            mask_reg_next = {access.data.write_data[7:3], ~access.data.write_data[2],
                             ~access.data.write_data[1], access.data.write_data[0]};
          end
          REG_SCROLL: begin
            if (!phase_flag) begin
              scroll_h_next = access.data.write_data;
            end else begin
              scroll_v_next = access.data.write_data;
            end
            phase_flag_next = !phase_flag;
          end
          REG_ADDRESS: begin
            if (!phase_flag) begin
              address_reg_next = {access.data.write_data[5:0], 8'h00};
            end else begin
              address_reg_next = {address_reg[13:8],
                                  address_reg[7:0] | access.data.write_data};
            end
            phase_flag_next = !phase_flag;
          end
          REG_DATA: begin
            half_write_next = phase_flag;
            if (address_reg >= PALETTE_BASE) begin
              pal_we = 1'b1;
            end else if (address_reg >= NAMETABLE_BASE) begin
              nt_we = 1'b1;
            end
            address_reg_next = address_reg + addr_step;
          end
          default: begin
          end
        endcase
      end
      ACT_PEEK: begin
        if (access.data.peek_address >= PALETTE_BASE) begin
          read_src_next = SRC_PALETTE;
          pal_re        = 1'b1;
        end else if (access.data.peek_address >= NAMETABLE_BASE) begin
          read_src_next = SRC_NAMETABLE;
          nt_re         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state and result slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_flag     <= 1'b0;
      nmi_enable     <= 1'b0;
      control_flags  <= 6'd0;
      mask_reg       <= MASK_RESET;
      scroll_h       <= 8'h00;
      scroll_v       <= 8'h00;
      address_reg    <= 14'd0;
      vblank_pending <= 1'b0;
      out_valid      <= 1'b0;
      half_write     <= 1'b0;
      read_src       <= SRC_ZERO;
    end else begin
      if (in_accept) begin
        phase_flag     <= phase_flag_next;
        nmi_enable     <= nmi_enable_next;
        control_flags  <= control_flags_next;
        mask_reg       <= mask_reg_next;
        scroll_h       <= scroll_h_next;
        scroll_v       <= scroll_v_next;
        address_reg    <= address_reg_next;
        vblank_pending <= vblank_pending_next;
        half_write     <= half_write_next;
        read_src       <= read_src_next;
        out_valid      <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Status byte is payload only.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      status_byte <= status_byte_next;
    end
  end

  // Palette memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (in_accept && pal_we) begin
      palette_mem[pal_waddr] <= mem_wdata[5:0];
    end
    if (in_accept && pal_re) begin
      pal_rdata <= palette_mem[pal_raddr];
    end
  end

  // Nametable memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (in_accept && nt_we) begin
      nametable_mem[nt_waddr] <= mem_wdata;
    end
    if (in_accept && nt_re) begin
      nt_rdata <= nametable_mem[nt_raddr];
    end
  end

  // Result beat. The register state already reflects this beat's access,
  // since the next access is only taken as this beat leaves.
  always_comb begin
    case (read_src)
      SRC_STATUS:    result.data.read_data = status_byte;
      SRC_PALETTE:   result.data.read_data = {2'b00, pal_rdata};
      SRC_NAMETABLE: result.data.read_data = nt_rdata;
      default:       result.data.read_data = 8'h00;
    endcase
    result.data.irq_enable         = nmi_enable;
    result.data.control_flags      = control_flags;
    result.data.mask_flags         = mask_reg;
    result.data.horizontal_scroll  = scroll_h;
    result.data.vertical_scroll    = scroll_v;
    result.data.video_address      = address_reg;
    result.data.latch_phase        = phase_flag;
    result.data.half_address_write = half_write;
  end

  assign result.valid = out_valid;

`ifndef NO_ASSERTIONS
  // Every accepted access yields a result beat in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted access produced no result beat");

  // A stalled result must block new accesses, or a beat would be lost.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |-> !access.ready)
    else $error("access taken while result stalled");

  // The half-address flag only follows a data register write.
  a_half_only_data: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !(act == ACT_WRITE && access.data.reg_select == REG_DATA))
    |=> !half_write)
    else $error("half-address flag set without a data write");

  // A status read leaves both vblank and the phase flag cleared.
  a_status_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && act == ACT_READ && access.data.reg_select == REG_STATUS)
    |=> (!vblank_pending && !phase_flag))
    else $error("status read did not clear vblank and phase");
`endif

endmodule
